FILE: sv/nta_pkg.sv
// ----------------------------------------------------------------------------
// Number-to-ASCII formatter package
// Shared types, character codes and helper functions for the formatter
// pipeline stages.
// ----------------------------------------------------------------------------
package nta_pkg;

    // Format mode codes as they arrive on the request channel.
    localparam logic [2:0] MODE_UDEC8 = 3'd0;
    localparam logic [2:0] MODE_SDEC8 = 3'd1;
    localparam logic [2:0] MODE_UDEC16 = 3'd2;
    localparam logic [2:0] MODE_HEX8 = 3'd3;
    localparam logic [2:0] MODE_HEX16 = 3'd4;

    // Text is at most five characters long.
    localparam int NUM_CHARS = 5;
    // Four divide-by-ten stages leave the top decimal digit as the quotient.
    localparam int DIV_STAGES = 4;

    // Reciprocal of ten: (n * 52429) >> 19 equals n / 10 for every 16-bit n.
    localparam logic [15:0] DIV10_MAGIC = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        FMT_DEC,
        FMT_HEX2,
        FMT_HEX4
    } fmt_t;

    // Item as it moves through the front end and the divider stages.
    typedef struct packed {
        fmt_t                        fmt;
        logic                        neg;
        logic [15:0]                 raw;
        logic [15:0]                 quot;
        logic [DIV_STAGES-1:0][3:0]  digits;
    } work_t;

    // Finished text: chars[0] is sent first.
    typedef struct packed {
        logic [NUM_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
    } text_t;

    function automatic logic [7:0] dec_char(input logic [3:0] d);
        return CHAR_ZERO + {4'h0, d};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'h0, nib};
        end
        else
        begin
            c = CHAR_UPPER_A + {4'h0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: sv/nta_front.sv
// ----------------------------------------------------------------------------
// Formatter front end
// Decodes the mode, takes the magnitude of a signed byte and registers the
// item for the divider chain. Requests with an unused mode are taken and
// dropped here.
// ----------------------------------------------------------------------------
module nta_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [2:0]     mode,
    input  logic [15:0]    value,
    output logic           out_valid,
    input  logic           out_stall,
    output nta_pkg::work_t out_item
);
    import nta_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    work_t  item_reg;
    work_t  item_next;
    logic   take;
    logic [7:0] low_byte;

    assign low_byte = value[7:0];
    assign in_stall = valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        item_next.fmt    = FMT_DEC;
        item_next.neg    = 1'b0;
        item_next.raw    = value;
        item_next.quot   = {8'h00, low_byte};
        item_next.digits = '0;
        valid_next       = 1'b1;
        unique case (mode)
            MODE_UDEC8:
            begin
                item_next.quot = {8'h00, low_byte};
            end
            MODE_SDEC8:
            begin
                // The negated byte is 1..128, which still fits in eight bits.
                item_next.neg = low_byte[7];
                if (low_byte[7])
                begin
                    item_next.quot = {8'h00, (~low_byte) + 8'd1};
                end
            end
            MODE_UDEC16:
            begin
                item_next.quot = value;
            end
            MODE_HEX8:
            begin
                item_next.fmt = FMT_HEX2;
            end
            MODE_HEX16:
            begin
                item_next.fmt = FMT_HEX4;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= take && valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: sv/nta_digit_stage.sv
// ----------------------------------------------------------------------------
// Divide-by-ten stage
// Splits one decimal digit off the running quotient with a reciprocal
// multiply and shifts it into the digit vector.
// ----------------------------------------------------------------------------
module nta_digit_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nta_pkg::work_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output nta_pkg::work_t out_item
);
    import nta_pkg::*;

    logic        valid_reg;
    work_t       item_reg;
    work_t       item_next;
    logic        take;
    logic [31:0] prod;
    logic [12:0] quot10;
    logic [15:0] times10;
    logic [15:0] rem16;

    assign in_stall = valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    assign prod    = {16'h0000, in_item.quot} * {16'h0000, DIV10_MAGIC};
    assign quot10  = prod[31:DIV10_SHIFT];
    assign times10 = {quot10, 3'b000} + {2'b00, quot10, 1'b0};
    assign rem16   = in_item.quot - times10;

    always_comb
    begin
        item_next        = in_item;
        item_next.quot   = {3'b000, quot10};
        item_next.digits = {rem16[3:0], in_item.digits[DIV_STAGES-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: sv/nta_pack.sv
// ----------------------------------------------------------------------------
// Text packing stage
// Turns digits or nibbles into ASCII, strips leading decimal zeros, adds the
// minus sign and counts the characters.
// ----------------------------------------------------------------------------
module nta_pack
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nta_pkg::work_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output nta_pkg::text_t out_text
);
    import nta_pkg::*;

    logic        valid_reg;
    text_t       text_reg;
    text_t       text_next;
    logic        take;
    logic [NUM_CHARS-1:0][3:0] dec;
    logic [NUM_CHARS-1:0][7:0] strip;
    logic [2:0]  lead;
    logic [2:0]  ndig;

    assign in_stall = valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    // dec[4] is the most significant digit.
    assign dec = {in_item.quot[3:0], in_item.digits};

    always_comb
    begin
        if (dec[4] != 4'd0)
        begin
            lead = 3'd0;
        end
        else if (dec[3] != 4'd0)
        begin
            lead = 3'd1;
        end
        else if (dec[2] != 4'd0)
        begin
            lead = 3'd2;
        end
        else if (dec[1] != 4'd0)
        begin
            lead = 3'd3;
        end
        else
        begin
            lead = 3'd4;
        end
    end

    assign ndig = 3'(NUM_CHARS) - lead;

    always_comb
    begin
        int k;
        for (int j = 0; j < NUM_CHARS; j++)
        begin
            k = j + int'(lead);
            if (k < NUM_CHARS)
            begin
                strip[j] = dec_char(dec[3'(NUM_CHARS - 1 - k)]);
            end
            else
            begin
                strip[j] = CHAR_ZERO;
            end
        end
    end

    always_comb
    begin
        text_next.chars = strip;
        text_next.count = ndig;
        unique case (in_item.fmt)
            FMT_DEC:
            begin
                if (in_item.neg)
                begin
                    text_next.chars = {strip[NUM_CHARS-2:0], CHAR_MINUS};
                    text_next.count = ndig + 3'd1;
                end
            end
            FMT_HEX2:
            begin
                text_next.chars[0] = hex_char(in_item.raw[7:4]);
                text_next.chars[1] = hex_char(in_item.raw[3:0]);
                text_next.count    = 3'd2;
            end
            FMT_HEX4:
            begin
                text_next.chars[0] = hex_char(in_item.raw[15:12]);
                text_next.chars[1] = hex_char(in_item.raw[11:8]);
                text_next.chars[2] = hex_char(in_item.raw[7:4]);
                text_next.chars[3] = hex_char(in_item.raw[3:0]);
                text_next.count    = 3'd4;
            end
            default:
            begin
                text_next.count = ndig;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            text_reg <= text_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_text  = text_reg;

endmodule

FILE: sv/nta_serializer.sv
// ----------------------------------------------------------------------------
// Character serializer
// Holds one finished text and sends it one character per unstalled cycle,
// loading the next text on the same edge that sends the last character.
// ----------------------------------------------------------------------------
module nta_serializer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nta_pkg::text_t in_text,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     char_code,
    output logic           last
);
    import nta_pkg::*;

    logic [NUM_CHARS-1:0][7:0] chars_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       busy_reg;
    logic       busy_next;
    logic       fire;
    logic       at_last;
    logic       take;

    assign at_last  = (idx_reg == cnt_reg - 3'd1);
    assign fire     = busy_reg && !out_stall;
    assign in_stall = busy_reg && !(fire && at_last);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            cnt_next  = in_text.count;
        end
        else if (fire && at_last)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chars_reg <= in_text.chars;
        end
    end

    assign out_valid = busy_reg;
    assign char_code = chars_reg[idx_reg];
    assign last      = busy_reg && at_last;

endmodule

FILE: sv/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Number-to-ASCII formatter
// Converts a value to decimal or hex ASCII text, one character per output
// request.
// ----------------------------------------------------------------------------
// A request carries mode and value on in_valid/in_stall. Modes 0..4 select
// unsigned byte decimal, signed byte decimal, unsigned 16-bit decimal, two
// hex digits and four hex digits. Modes 5..7 are taken and give no output.
// Each output request on out_valid/out_stall carries one ASCII character,
// with last high on the final character of the input request.
// The front end and four divide-by-ten stages and a packing stage form a
// six-stage pipeline, followed by the serializer register, which a request
// passes through before its first character is on the output. The output
// port sends one character per cycle while out_stall is low, and the next
// request's first character follows the previous request's last one with no
// gap when the packing stage already holds its text. A request has one to
// five characters. A new request can enter every cycle while the pipeline
// has room; in_stall rises once it fills.
// Reset clears all valid bits, so nothing is sent after reset until a new
// request is taken. When the receiver stalls, the current character and last
// hold and the stall backs up through the pipeline to in_stall; no request
// is lost or repeated.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_code,
    output logic        last
);
    import nta_pkg::*;

    // Handshake and payload between consecutive stages. Index 0 is the front
    // end output, index DIV_STAGES the last divider output.
    logic  [DIV_STAGES:0] stg_valid;
    logic  [DIV_STAGES:0] stg_stall;
    work_t                stg_item [DIV_STAGES+1];
    logic                 pack_valid;
    logic                 pack_stall;
    text_t                pack_text;

    nta_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .out_valid (stg_valid[0]),
        .out_stall (stg_stall[0]),
        .out_item  (stg_item[0])
    );

    // One digit is split off per stage, least significant first.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        nta_digit_stage u_digit
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_stall  (stg_stall[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_stall (stg_stall[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    nta_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[DIV_STAGES]),
        .in_stall  (stg_stall[DIV_STAGES]),
        .in_item   (stg_item[DIV_STAGES]),
        .out_valid (pack_valid),
        .out_stall (pack_stall),
        .out_text  (pack_text)
    );

    nta_serializer u_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pack_valid),
        .in_stall  (pack_stall),
        .in_text   (pack_text),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

endmodule

FILE: sv/nta_checker.sv
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the output channel of the formatter and is bound to its top level.
// ----------------------------------------------------------------------------
module nta_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  char_code,
    input logic        last
);
    import nta_pkg::*;

    // A stalled output request stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    // Every character sent is a digit, an uppercase hex letter or a minus.
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)) ||
            ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F)) ||
            (char_code == CHAR_MINUS))
        else $error("illegal character on output");

    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_code == CHAR_MINUS) |-> !last)
        else $error("minus sign marked as last character");

    // A minus only opens a request, so it never follows a character of the
    // same request.
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |->
            (char_code != CHAR_MINUS))
        else $error("minus sign inside a request");

endmodule

bind number_to_ascii_formatter nta_checker u_nta_checker (.*);
